FILE: hdl/cci_pkg.sv
package cci_pkg;

  localparam int MaxPointsDefault = 32;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_EMPTY  = 3'd0,
    REG_SINGLE = 3'd1,
    REG_BELOW  = 3'd2,
    REG_INSIDE = 3'd3,
    REG_ABOVE  = 3'd4
  } region_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_Q_RD,
    S_Q_CMP,
    S_Q_SETUP,
    S_Q_DIV,
    S_Q_MUL,
    S_Q_MULW,
    S_Q_FIN,
    S_OUT
  } state_t;

  localparam int FreqW = 64;
  localparam int ValW = 16;
  localparam int EntryW = FreqW + 4 * ValW;

  localparam logic [16:0] UncEmpty = 17'd25344;
  localparam logic [16:0] UncSingle = 17'd768;
  localparam logic [16:0] UncEdge = 17'd512;

endpackage

FILE: hdl/cci_ram.sv
module cci_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/calibration_curve_interpolator_unit.sv
// channel | dir | tdata, low bit up                                          | tuser
// s_axis  | in  | frequency[63:0] gain_in noise_in phase_in uncert_in (128b)  | mode[1:0]
// m_axis  | out | gain_out noise_out phase_out uncert_out region status (72b) | -
//
// One request at a time; s_axis_tready is high only in idle.
// Work from the accept edge to m_axis_tvalid: clear, unused mode, full insert and empty
// query go straight to the result; insert reads and compares points from the top, then
// writes; single-point query reads one entry; other queries read and compare each point
// walked, set up, take 16 divide steps (skipped at the span end), three multiplies, a finish.
// rst clears point count and control only. The result holds until m_axis_tready.
module calibration_curve_interpolator_unit #(
  parameter int MAX_POINTS = cci_pkg::MaxPointsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // frequency, gain_in, noise_in, phase_in, uncert_in
  input  logic [1:0]   s_axis_tuser,   // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata    // gain_out, noise_out, phase_out, uncert_out,
                                       // region, status, zero fill
);
  import cci_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_POINTS);

  state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] ins_at;
  logic [CW-1:0] last_idx, idx_inc;
  logic [63:0]   freq;
  logic [15:0]   g_in, n_in, p_in, u_in;
  logic          is_insert, is_query;

  // left / right entry
  logic [63:0] fl, fr;
  logic signed [15:0] gl, nl, pl, gr, nr, pr;
  logic [15:0] ul, ur;

  // divider and multiplier
  logic [63:0] rem, den;
  logic [16:0] pos;
  logic [3:0]  step;
  logic [1:0]  mcnt;
  logic signed [16:0] mdiff;
  logic signed [34:0] mul_res;
  logic signed [15:0] go, no, po;
  logic [16:0] uo;
  logic [2:0]  region;
  logic        status;
  logic        zero_span;
  logic        walk_stop;

  logic [63:0] fq, span_num, span_den;
  logic [63:0] rem_sh;
  logic        carry;
  logic [64:0] rem_sub;

  logic [16:0] dev, umax, usum, unc_fin, usingle;

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;

  logic [63:0] rd_f;
  logic [15:0] rd_g, rd_n, rd_p, rd_u;

  cci_ram #(.Width(EntryW), .Depth(MAX_POINTS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign {rd_u, rd_p, rd_n, rd_g, rd_f} = rdata;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {4'd0, status, region, uo[15:0], po, no, go};

  assign is_insert = (mode_t'(s_axis_tuser) == MODE_INSERT);
  assign is_query = (mode_t'(s_axis_tuser) == MODE_QUERY);

  assign last_idx = count - CW'(1);
  assign idx_inc = idx + CW'(1);
  assign raddr = idx[AW-1:0];

  // query walk ends on the first pair when below, on the pair that brackets the frequency, or on the last pair
  assign walk_stop = (idx != '0) &&
                     (region == REG_BELOW || freq <= rd_f || idx == last_idx);

  // edges clamp the position to the end point of the pair
  assign fq = (region == REG_BELOW) ? fl : (region == REG_ABOVE) ? fr : freq;
  assign span_num = fq - fl;
  assign span_den = fr - fl;

  assign carry = rem[63];
  assign rem_sh = {rem[62:0], 1'b0};
  assign rem_sub = {1'b0, rem_sh} - {1'b0, den};

  // one shared multiplier: 17x18 signed
  assign mul_res = mdiff * $signed({1'b0, pos});

  always_comb begin
    dev = (pos >= 17'd32768) ? pos - 17'd32768 : 17'd32768 - pos;
    umax = (ul > ur) ? 17'(ul) : 17'(ur);
    usum = zero_span ? 17'(ul) : umax + (dev >> 10);
    if (region == REG_BELOW || region == REG_ABOVE) usum = usum + UncEdge;
    unc_fin = (usum > 17'hFFFF) ? 17'hFFFF : usum;
    usingle = 17'(rd_u) + UncSingle;
    if (usingle > 17'hFFFF) usingle = 17'hFFFF;
  end

  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = idx_inc[AW-1:0];
    wdata = rdata;
    unique case (state)
      S_IDLE: if (s_axis_tvalid) begin
        unique case (mode_t'(s_axis_tuser))
          MODE_INSERT: begin
            if (count >= CntMax) state_next = S_OUT;
            else if (count == '0) state_next = S_INS_PUT;
            else state_next = S_INS_RD;
          end
          MODE_QUERY: state_next = (count == '0) ? S_OUT : S_Q_RD;
          default: state_next = S_OUT;
        endcase
      end
      S_INS_RD: state_next = S_INS_CMP;
      // entries above the new frequency move up one place, scanning from the top
      S_INS_CMP: begin
        if (rd_f > freq) begin
          we = 1'b1;
          state_next = (idx == '0) ? S_INS_PUT : S_INS_RD;
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        we = 1'b1;
        waddr = ins_at[AW-1:0];
        wdata = {u_in, p_in, n_in, g_in, freq};
        state_next = S_OUT;
      end
      S_Q_RD: state_next = S_Q_CMP;
      S_Q_CMP: begin
        if (region == REG_SINGLE) state_next = S_OUT;
        else if (walk_stop) state_next = S_Q_SETUP;
        else state_next = S_Q_RD;
      end
      S_Q_SETUP: state_next = (span_num >= span_den) ? S_Q_MUL : S_Q_DIV;
      S_Q_DIV: state_next = (step == 4'd15) ? S_Q_MUL : S_Q_DIV;
      S_Q_MUL: state_next = S_Q_MULW;
      S_Q_MULW: state_next = (mcnt == 2'd2) ? S_Q_FIN : S_Q_MUL;
      S_Q_FIN: state_next = S_OUT;
      S_OUT: if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && s_axis_tvalid && mode_t'(s_axis_tuser) == MODE_CLEAR) begin
        count <= '0;
      end
      if (state == S_INS_PUT) count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (s_axis_tvalid) begin
        {u_in, p_in, n_in, g_in, freq} <= s_axis_tdata;
        idx <= is_insert ? last_idx : '0;
        ins_at <= '0;
        go <= '0;
        no <= '0;
        po <= '0;
        uo <= (is_query && count == '0) ? UncEmpty : 17'd0;
        status <= is_insert && (count >= CntMax);
        if (!is_query || count == '0) region <= REG_EMPTY;
        else if (count == CW'(1)) region <= REG_SINGLE;
        else region <= REG_INSIDE;
      end
      S_INS_CMP: begin
        if (rd_f > freq) idx <= idx - CW'(1);
        else ins_at <= idx_inc;
      end
      S_Q_CMP: begin
        // previous right becomes left
        fl <= fr; gl <= gr; nl <= nr; pl <= pr; ul <= ur;
        fr <= rd_f; gr <= rd_g; nr <= rd_n; pr <= rd_p; ur <= rd_u;
        if (region == REG_SINGLE) begin
          go <= rd_g;
          no <= rd_n;
          po <= rd_p;
          uo <= usingle;
        end
        if (idx == '0) begin
          if (region == REG_INSIDE && freq <= rd_f) region <= REG_BELOW;
          idx <= CW'(1);
        end else if (walk_stop) begin
          if (region == REG_INSIDE && freq > rd_f) region <= REG_ABOVE;
        end else begin
          idx <= idx_inc;
        end
      end
      S_Q_SETUP: begin
        zero_span <= (fr <= fl);
        rem <= span_num;
        den <= span_den;
        pos <= (span_num >= span_den) ? 17'h10000 : 17'd0;
        step <= '0;
        mcnt <= '0;
      end
      S_Q_DIV: begin
        step <= step + 4'd1;
        if (carry || !rem_sub[64]) begin
          rem <= rem_sub[63:0];
          pos <= {pos[15:0], 1'b1};
        end else begin
          rem <= rem_sh;
          pos <= {pos[15:0], 1'b0};
        end
      end
      S_Q_MUL: begin
        case (mcnt)
          2'd0: mdiff <= 17'(gr) - 17'(gl);
          2'd1: mdiff <= 17'(nr) - 17'(nl);
          default: mdiff <= 17'(pr) - 17'(pl);
        endcase
      end
      S_Q_MULW: begin
        mcnt <= mcnt + 2'd1;
        case (mcnt)
          2'd0: go <= zero_span ? gl : 16'(gl + 16'(mul_res >>> 16));
          2'd1: no <= zero_span ? nl : 16'(nl + 16'(mul_res >>> 16));
          default: po <= zero_span ? pl : 16'(pl + 16'(mul_res >>> 16));
        endcase
      end
      S_Q_FIN: uo <= unc_fin;
      default: ;
    endcase
  end

endmodule

FILE: test/cci_checker.sv
`timescale 1ns / 1ps

module cci_checker #(
  parameter int MAX_POINTS = cci_pkg::MaxPointsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [71:0]  m_axis_tdata,
  output int           fail_count,
  output int           pending,
  output int           query_count
);
  import cci_pkg::*;

  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] noise;
    logic [15:0] phase;
    logic [15:0] uncert;
    logic [2:0]  region;
    logic        status;
  } corr_t;

  logic [63:0] tbl_freq[MAX_POINTS];
  logic signed [15:0] tbl_gain[MAX_POINTS];
  logic signed [15:0] tbl_noise[MAX_POINTS];
  logic signed [15:0] tbl_phase[MAX_POINTS];
  logic [15:0] tbl_unc[MAX_POINTS];
  int tbl_count;
  corr_t expected_corr[$];

  function automatic logic [16:0] fraction16(logic [63:0] num, logic [63:0] den);
    logic [64:0] r;
    logic [16:0] q;
    q = 0;
    if (num >= den) return 17'd65536;
    r = {1'b0, num};
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [15:0] blend(logic signed [15:0] l, logic signed [15:0] r,
                                        logic [16:0] pos);
    logic signed [17:0] d;
    logic signed [35:0] prod;
    d = r - l;
    prod = d * $signed({1'b0, pos});
    return l + 16'(prod >>> 16);  // arithmetic shift floors
  endfunction

  function automatic corr_t span_lookup(int a, int b, logic [63:0] f);
    corr_t c;
    logic [16:0] pos, dev;
    logic [16:0] sum;
    c = '0;
    if (tbl_freq[b] <= tbl_freq[a]) begin
      c.gain = tbl_gain[a];
      c.noise = tbl_noise[a];
      c.phase = tbl_phase[a];
      c.uncert = tbl_unc[a];
      return c;
    end
    pos = fraction16(f - tbl_freq[a], tbl_freq[b] - tbl_freq[a]);
    c.gain = blend(tbl_gain[a], tbl_gain[b], pos);
    c.noise = blend(tbl_noise[a], tbl_noise[b], pos);
    c.phase = blend(tbl_phase[a], tbl_phase[b], pos);
    dev = pos >= 17'd32768 ? pos - 17'd32768 : 17'd32768 - pos;
    sum = (tbl_unc[a] > tbl_unc[b] ? tbl_unc[a] : tbl_unc[b]) + (dev >> 10);
    c.uncert = sum > 17'd65535 ? 16'hFFFF : sum[15:0];
    return c;
  endfunction

  function automatic corr_t apply_request(mode_t mode, logic [127:0] d);
    corr_t c;
    logic [63:0] f;
    logic [16:0] u;
    int at, i;
    c = '0;
    f = d[63:0];
    case (mode)
      MODE_CLEAR: tbl_count = 0;
      MODE_INSERT: begin
        if (tbl_count >= MAX_POINTS) begin
          c.status = 1'b1;
        end else begin
          at = 0;
          while (at < tbl_count && tbl_freq[at] <= f) at++;
          for (i = tbl_count; i > at; i--) begin
            tbl_freq[i] = tbl_freq[i-1];
            tbl_gain[i] = tbl_gain[i-1];
            tbl_noise[i] = tbl_noise[i-1];
            tbl_phase[i] = tbl_phase[i-1];
            tbl_unc[i] = tbl_unc[i-1];
          end
          tbl_freq[at] = f;
          tbl_gain[at] = d[79:64];
          tbl_noise[at] = d[95:80];
          tbl_phase[at] = d[111:96];
          tbl_unc[at] = d[127:112];
          tbl_count++;
        end
      end
      MODE_QUERY: begin
        if (tbl_count == 0) begin
          c.uncert = UncEmpty[15:0];
          c.region = REG_EMPTY;
        end else if (tbl_count == 1) begin
          c.gain = tbl_gain[0];
          c.noise = tbl_noise[0];
          c.phase = tbl_phase[0];
          u = tbl_unc[0] + UncSingle;
          c.uncert = u > 17'd65535 ? 16'hFFFF : u[15:0];
          c.region = REG_SINGLE;
        end else if (f <= tbl_freq[0]) begin
          c = span_lookup(0, 1, tbl_freq[0]);
          u = c.uncert + UncEdge;
          c.uncert = u > 17'd65535 ? 16'hFFFF : u[15:0];
          c.region = REG_BELOW;
        end else if (f > tbl_freq[tbl_count-1]) begin
          c = span_lookup(tbl_count - 2, tbl_count - 1, tbl_freq[tbl_count-1]);
          u = c.uncert + UncEdge;
          c.uncert = u > 17'd65535 ? 16'hFFFF : u[15:0];
          c.region = REG_ABOVE;
        end else begin
          i = 1;
          while (i < tbl_count - 1 && f > tbl_freq[i]) i++;
          c = span_lookup(i - 1, i, f);
          c.region = REG_INSIDE;
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  always @(posedge clk) begin
    corr_t want, got;
    if (rst) begin
      tbl_count = 0;
      fail_count <= 0;
      query_count <= 0;
      pending <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_corr = {expected_corr,
                         apply_request(mode_t'(s_axis_tuser), s_axis_tdata)};
        if (s_axis_tuser == MODE_QUERY) query_count <= query_count + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
               m_axis_tdata[63:48], m_axis_tdata[66:64], m_axis_tdata[67]};
        if (expected_corr.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_corr.pop_front();
          if (want != got) begin
            $display("%0t: mismatch expected g=%h n=%h p=%h u=%h r=%0d s=%0d",
                     $time, want.gain, want.noise, want.phase, want.uncert,
                     want.region, want.status);
            $display("%0t:          actual   g=%h n=%h p=%h u=%h r=%0d s=%0d",
                     $time, got.gain, got.noise, got.phase, got.uncert,
                     got.region, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_corr.size();
    end
  end

endmodule

FILE: test/tb_calibration_curve_interpolator_unit.sv
`timescale 1ns / 1ps

module tb_calibration_curve_interpolator_unit;
  import cci_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = MODE_CLEAR;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  int fail_count, pending, query_count;
  int idle_cycles = 0;
  int sent = 0;
  logic stim_done = 1'b0;
  logic [63:0] freq_pool[8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  calibration_curve_interpolator_unit i_dut (.*);

  cci_checker i_checker (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) < 65);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // valid stays up after an accept unless a gap follows
  task automatic send(mode_t mode, logic [63:0] f, logic [15:0] g, logic [15:0] n,
                      logic [15:0] p, logic [15:0] u);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {u, p, n, g, f};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic logic [63:0] rnd_freq();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return freq_pool[$urandom_range(0, 7)];
      2: return freq_pool[$urandom_range(0, 7)] + $urandom_range(0, 1000) - 500;
      default: return 64'($urandom_range(0, 100000));
    endcase
  endfunction

  task automatic rnd_insert();
    send(MODE_INSERT, rnd_freq(), rnd16(), rnd16(), rnd16(), rnd16());
  endtask

  task automatic rnd_query();
    send(MODE_QUERY, rnd_freq(), rnd16(), rnd16(), rnd16(), rnd16());
  endtask

  initial begin
    int n;
    for (int i = 0; i < 8; i++) freq_pool[i] = {$urandom, $urandom} >> $urandom_range(0, 60);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty, single, edges, zero span, extremes, full table, unused mode
    send(MODE_QUERY, 64'd5, 16'h0, 16'h0, 16'h0, 16'h0);
    send(MODE_NONE, '1, '1, '1, '1, '1);
    send(MODE_INSERT, 64'd1000, 16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF);
    send(MODE_QUERY, 64'd0, 16'h0, 16'h0, 16'h0, 16'h0);
    send(MODE_INSERT, 64'd1000, 16'h8000, 16'h7FFF, 16'hEDCB, 16'h0000);
    send(MODE_QUERY, 64'd1000, 16'h0, 16'h0, 16'h0, 16'h0);
    send(MODE_INSERT, 64'd3000, 16'h8000, 16'h7FFF, 16'h8000, 16'hFF00);
    send(MODE_QUERY, 64'd2000, 16'h0, 16'h0, 16'h0, 16'h0);
    send(MODE_QUERY, 64'd3000, 16'h0, 16'h0, 16'h0, 16'h0);
    send(MODE_QUERY, 64'd1001, 16'h0, 16'h0, 16'h0, 16'h0);
    send(MODE_QUERY, '1, 16'h0, 16'h0, 16'h0, 16'h0);
    send(MODE_INSERT, '1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send(MODE_QUERY, 64'hFFFF_FFFF_FFFF_FFFE, '1, '1, '1, '1);
    send(MODE_INSERT, 64'd0, 16'h8000, 16'h8000, 16'h8000, 16'h0100);
    send(MODE_QUERY, 64'h8000_0000_0000_0000, 16'h0, 16'h0, 16'h0, 16'h0);
    for (int i = 0; i < 30; i++) rnd_insert();  // overflows the table
    send(MODE_QUERY, 64'd2500, 16'h0, 16'h0, 16'h0, 16'h0);
    send(MODE_CLEAR, '1, '1, '1, '1, '1);
    send(MODE_QUERY, 64'd2500, 16'h0, 16'h0, 16'h0, 16'h0);
    // random: build tables of varied size, then query them
    while (sent < 1150) begin
      for (int i = 0; i < 8; i++) freq_pool[i] = {$urandom, $urandom} >> $urandom_range(0, 60);
      send(MODE_CLEAR, rnd_freq(), rnd16(), rnd16(), rnd16(), rnd16());
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 8);
      for (int i = 0; i < n; i++) rnd_insert();
      n = $urandom_range(5, 25);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 19))
          0: send(mode_t'($urandom_range(0, 3)), rnd_freq(), rnd16(), rnd16(), rnd16(),
                  rnd16());
          1, 2: rnd_insert();
          default: rnd_query();
        endcase
      end
    end
    s_axis_tvalid <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    int waited;
    waited = 0;
    wait (stim_done);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    while (waited < 300) begin
      @(posedge clk);
      waited++;
    end
    $display("Sent %0d requests (%0d queries) through clear, insert and query,", sent,
             query_count);
    $display("covering empty, single, edge, inside, zero-span and full-table cases.");
    if (pending != 0) $display("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
